/* src/stable_merge_sort_pairs_top_assert.svh */
// Assertion macros for the stable merge sort block.
// Used by stable_merge_sort_pairs_top; expects clk and rst_n in scope.
`ifndef STABLE_MERGE_SORT_PAIRS_TOP_ASSERT_SVH
`define STABLE_MERGE_SORT_PAIRS_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define SMSP_ASSERT(label, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("smsp assertion failed");
`define SMSP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("smsp assertion failed");
`else
`define SMSP_ASSERT(label, expr)
`define SMSP_ASSERT_NEXT(label, ante, cons)
`endif
`endif

/* src/smsp_pkg.sv */
// Shared types and constants of the stable merge sort block.
// No dependencies.
`default_nettype none
package smsp_pkg;
  localparam int CAPACITY_DEF = 64;
  localparam int INDEX_W      = 31;
  localparam int VALUE_W      = 32;

  typedef struct packed {
    logic [INDEX_W-1:0]        index;
    logic signed [VALUE_W-1:0] value;
  } pair_t;

  typedef struct packed {
    logic load;
    logic sort_start;
    logic run_start;
    logic merge_move;
    logic next_run;
    logic next_pass;
    logic emit_start;
    logic emit_load;
    logic set_clear;
  } dp_cmd_t;

  typedef struct packed {
    logic sort_skip;
    logic run_done;
    logic last_run;
    logic last_pass;
    logic emit_last;
  } dp_status_t;
endpackage
`default_nettype wire

/* src/smsp_in_if.sv */
// Input channel of the sort block: valid/ready plus one pair item.
// Depends on smsp_pkg.
`default_nettype none
interface smsp_in_if;
  import smsp_pkg::*;
  logic                      valid;
  logic                      ready;
  logic [INDEX_W-1:0]        page_index;
  logic signed [VALUE_W-1:0] sort_value;
  logic                      last_in;

  modport source (output valid, page_index, sort_value, last_in, input ready);
  modport sink   (input valid, page_index, sort_value, last_in, output ready);
endinterface
`default_nettype wire

/* src/smsp_out_if.sv */
// Result channel of the sort block: valid/ready plus one sorted item.
// Depends on smsp_pkg.
`default_nettype none
interface smsp_out_if;
  import smsp_pkg::*;
  logic                      valid;
  logic                      ready;
  logic [INDEX_W-1:0]        out_index;
  logic signed [VALUE_W-1:0] out_value;
  logic                      last_out;
  logic                      overflowed;

  modport source (output valid, out_index, out_value, last_out, overflowed, input ready);
  modport sink   (input valid, out_index, out_value, last_out, overflowed, output ready);
endinterface
`default_nettype wire

/* src/stable_merge_sort_pairs_top.sv */
// Stable merge sort of (index, value) pairs. Loading accepts one item per cycle.
// Sort: ceil(log2 n) bottom-up passes of a one-compare merge loop over two
// registered-read memories; each element is read (S_RD), then moved (S_MV).
// Emission: each result is loaded into the output register and held until
// out ready takes it. Sync active-low reset clears count, flags and
// sequencer; pair memories are not cleared.
`default_nettype none
`include "stable_merge_sort_pairs_top_assert.svh"
module stable_merge_sort_pairs_top #(
  parameter int CAPACITY = smsp_pkg::CAPACITY_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  smsp_in_if.sink     in_ch,
  smsp_out_if.source  out_ch
);
  import smsp_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t stat;
  pair_t      in_pair, out_pair;
  logic       out_last, out_ovf;

  assign in_pair.index = in_ch.page_index;
  assign in_pair.value = in_ch.sort_value;

  smsp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_last   (in_ch.last_in),
    .in_ready  (in_ch.ready),
    .out_ready (out_ch.ready),
    .out_valid (out_ch.valid),
    .cmd       (cmd),
    .stat      (stat)
  );

  smsp_dp #(.CAPACITY(CAPACITY)) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_pair  (in_pair),
    .cmd      (cmd),
    .stat     (stat),
    .out_pair (out_pair),
    .out_last (out_last),
    .out_ovf  (out_ovf)
  );

  assign out_ch.out_index  = out_pair.index;
  assign out_ch.out_value  = out_pair.value;
  assign out_ch.last_out   = out_last;
  assign out_ch.overflowed = out_ovf;

  `SMSP_ASSERT(a_no_overlap, !(in_ch.ready && out_ch.valid))
  `SMSP_ASSERT_NEXT(a_set_closes, in_ch.valid && in_ch.ready && in_ch.last_in, !in_ch.ready)
  `SMSP_ASSERT_NEXT(a_last_ends, out_ch.valid && out_ch.ready && out_ch.last_out, !out_ch.valid)
  `SMSP_ASSERT(a_move_in_run, !cmd.merge_move || !stat.run_done)
endmodule
`default_nettype wire

/* src/smsp_ctrl.sv */
// Sequencer of the sort block: load, merge passes, emission.
// Depends on smsp_pkg; drives smsp_dp through dp_cmd_t.
`default_nettype none
module smsp_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_last,
  output logic                 in_ready,
  input  logic                 out_ready,
  output logic                 out_valid,
  output smsp_pkg::dp_cmd_t    cmd,
  input  smsp_pkg::dp_status_t stat
);
  import smsp_pkg::*;

  typedef enum logic [3:0] {
    S_LOAD, S_SORT_INIT, S_RUN_INIT, S_RD, S_MV, S_RUN_END,
    S_EMIT_RD, S_EMIT_LD, S_EMIT_WAIT
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    cmd           = '0;
    case (state_r)
      S_LOAD: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          if (in_last) state_nxt = S_SORT_INIT;
        end
      end
      S_SORT_INIT: begin
        cmd.sort_start = 1'b1;
        if (stat.sort_skip) begin
          cmd.emit_start = 1'b1;
          state_nxt      = S_EMIT_RD;
        end else begin
          state_nxt = S_RUN_INIT;
        end
      end
      S_RUN_INIT: begin
        cmd.run_start = 1'b1;
        state_nxt     = S_RD;
      end
      S_RD: begin
        state_nxt = stat.run_done ? S_RUN_END : S_MV;
      end
      S_MV: begin
        cmd.merge_move = 1'b1;
        state_nxt      = S_RD;
      end
      S_RUN_END: begin
        if (!stat.last_run) begin
          cmd.next_run = 1'b1;
          state_nxt    = S_RUN_INIT;
        end else begin
          cmd.next_pass = 1'b1;
          if (stat.last_pass) begin
            cmd.emit_start = 1'b1;
            state_nxt      = S_EMIT_RD;
          end else begin
            state_nxt = S_RUN_INIT;
          end
        end
      end
      S_EMIT_RD: begin
        state_nxt = S_EMIT_LD;
      end
      S_EMIT_LD: begin
        cmd.emit_load = 1'b1;
        out_valid_nxt = 1'b1;
        state_nxt     = S_EMIT_WAIT;
      end
      S_EMIT_WAIT: begin
        if (out_ready) begin
          out_valid_nxt = 1'b0;
          if (stat.emit_last) begin
            cmd.set_clear = 1'b1;
            state_nxt     = S_LOAD;
          end else begin
            state_nxt = S_EMIT_LD;
          end
        end
      end
      default: begin
        state_nxt     = S_LOAD;
        out_valid_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_LOAD;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == S_LOAD);
  assign out_valid = out_valid_r;
endmodule
`default_nettype wire

/* src/smsp_dp.sv */
// Datapath of the sort block: two ping-pong pair memories, merge pointers,
// set count and the output register. Depends on smsp_pkg; driven by smsp_ctrl.
`default_nettype none
module smsp_dp #(
  parameter int CAPACITY = smsp_pkg::CAPACITY_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  smsp_pkg::pair_t      in_pair,
  input  smsp_pkg::dp_cmd_t    cmd,
  output smsp_pkg::dp_status_t stat,
  output smsp_pkg::pair_t      out_pair,
  output logic                 out_last,
  output logic                 out_ovf
);
  import smsp_pkg::*;

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int WW = CW + 1;
  localparam int SW = CW + 2;

  pair_t mem0 [CAPACITY];
  pair_t mem1 [CAPACITY];
  pair_t rd0a_r, rd0b_r, rd1a_r, rd1b_r;

  logic [CW-1:0] cnt_r, lo_r, a_r, b_r, k_r;
  logic [WW-1:0] width_r;
  logic          ovf_r, bank_r;
  pair_t         out_pair_r;
  logic          out_last_r, out_ovf_r;

  logic [SW-1:0] n_ext, mid_raw, hi_raw, w2;
  logic [CW-1:0] mid, hi;
  pair_t         src_a, src_b, mv_pair;
  logic          take_a, room;

  always_comb begin
    n_ext   = SW'(cnt_r);
    w2      = SW'(width_r) << 1;
    mid_raw = SW'(lo_r) + SW'(width_r);
    hi_raw  = SW'(lo_r) + w2;
    mid     = (mid_raw > n_ext) ? cnt_r : CW'(mid_raw);
    hi      = (hi_raw > n_ext) ? cnt_r : CW'(hi_raw);
    src_a   = bank_r ? rd1a_r : rd0a_r;
    src_b   = bank_r ? rd1b_r : rd0b_r;
    take_a  = (a_r < mid) &&
              ((b_r >= hi) || ($signed(src_a.value) <= $signed(src_b.value)));
    mv_pair = take_a ? src_a : src_b;
    room    = (cnt_r < CW'(CAPACITY));
  end

  assign stat.sort_skip = (cnt_r < CW'(2));
  assign stat.run_done  = (k_r == hi);
  assign stat.last_run  = (hi_raw >= n_ext);
  assign stat.last_pass = (w2 >= n_ext);
  assign stat.emit_last = out_last_r;

  always_ff @(posedge clk) begin
    if (cmd.load && room) begin
      mem0[cnt_r[AW-1:0]] <= in_pair;
    end else if (cmd.merge_move && bank_r) begin
      mem0[k_r[AW-1:0]] <= mv_pair;
    end
    if (cmd.merge_move && !bank_r) begin
      mem1[k_r[AW-1:0]] <= mv_pair;
    end
    rd0a_r <= mem0[a_r[AW-1:0]];
    rd0b_r <= mem0[b_r[AW-1:0]];
    rd1a_r <= mem1[a_r[AW-1:0]];
    rd1b_r <= mem1[b_r[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_load) begin
      out_pair_r <= src_a;
      out_last_r <= ((SW'(a_r) + SW'(1)) == n_ext);
      out_ovf_r  <= ovf_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r   <= '0;
      ovf_r   <= 1'b0;
      bank_r  <= 1'b0;
      width_r <= '0;
      lo_r    <= '0;
      a_r     <= '0;
      b_r     <= '0;
      k_r     <= '0;
    end else begin
      if (cmd.load) begin
        if (room) cnt_r <= cnt_r + CW'(1);
        else      ovf_r <= 1'b1;
      end
      if (cmd.sort_start) begin
        width_r <= WW'(1);
        lo_r    <= '0;
      end
      if (cmd.run_start) begin
        a_r <= lo_r;
        b_r <= mid;
        k_r <= lo_r;
      end
      if (cmd.merge_move) begin
        k_r <= k_r + CW'(1);
        if (take_a) a_r <= a_r + CW'(1);
        else        b_r <= b_r + CW'(1);
      end
      if (cmd.next_run) lo_r <= CW'(hi_raw);
      if (cmd.next_pass) begin
        width_r <= WW'(w2);
        lo_r    <= '0;
        bank_r  <= ~bank_r;
      end
      if (cmd.emit_start) a_r <= '0;
      if (cmd.emit_load)  a_r <= a_r + CW'(1);
      if (cmd.set_clear) begin
        cnt_r  <= '0;
        ovf_r  <= 1'b0;
        bank_r <= 1'b0;
      end
    end
  end

  assign out_pair = out_pair_r;
  assign out_last = out_last_r;
  assign out_ovf  = out_ovf_r;
endmodule
`default_nettype wire
